>>> design/dsi_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, register codes and helpers for the damped spring integrator.
package dsi_pkg;

  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int STEP_W    = 17;
  localparam int PROD_W    = 50;
  localparam int ACC_W     = 44;
  localparam int QUO_W     = 42;
  localparam int COEF_FRAC = 8;
  localparam int MS_PER_S  = 1000;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 3'd4;

  localparam logic [COEF_W-1:0] TOL_RESET = 16'd655;
  localparam logic [COEF_W-1:0] MIN_RESET = 16'd10;
  localparam logic [COEF_W-1:0] MAX_RESET = 16'd2000;

  typedef logic signed [DATA_W-1:0] q_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic q_word_t sat_word(input logic signed [63:0] x);
    q_word_t r;
    if (x > 64'sh0000_0000_7fff_ffff) begin
      r = 32'h7fff_ffff;
    end else if (x < 64'shffff_ffff_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/dsi_div1000.sv
`timescale 1ns / 1ps
// Floor division of a signed product by 1000, one 16-bit digit at a time by reciprocal multiply.
module dsi_div1000 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [dsi_pkg::PROD_W-1:0]   dividend,
  output logic signed [dsi_pkg::QUO_W-1:0]    quotient,
  output dsi_pkg::div_stat_t                  stat
);
  import dsi_pkg::*;

  // Three 16-bit digits cover any product of a 32-bit word and a 16-bit interval.
  localparam int DIG_W   = 16;
  localparam int N_DIG   = 3;
  localparam int WORK_W  = DIG_W * N_DIG;
  localparam int REM_W   = $clog2(MS_PER_S);
  localparam int PART_W  = REM_W + DIG_W;
  localparam int RCP_W   = 27;
  localparam int RCP_SH  = 36;
  localparam int RPROD_W = PART_W + RCP_W;
  localparam int CNT_W   = 2;

  // This is 2^36 / 1000 rounded up. The rounding error stays below one part in 1000
  // for every partial dividend under 1000 * 2^16, so the shifted product is exact.
  localparam logic [RCP_W-1:0] RECIP = 27'd68719477;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_REM  = 2'd2;
  localparam logic [1:0] D_FIX  = 2'd3;

  logic [1:0]               st_r, st_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     neg_r, neg_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [WORK_W-1:0]        work_r, work_nxt;
  logic [PART_W-1:0]        part_r, part_nxt;
  logic [RPROD_W-1:0]       rprod_r, rprod_nxt;
  logic [WORK_W-1:0]        acc_r, acc_nxt;
  logic signed [QUO_W-1:0]  quo_r, quo_nxt;
  logic                     done_r, done_nxt;
  logic [WORK_W-1:0]        mag;
  logic [PART_W-1:0]        part;
  logic [DIG_W-1:0]         digit_q;
  logic [PART_W-1:0]        back;

  always_comb begin
    // A negative dividend is biased by 999 so that the signed quotient rounds down.
    mag       = dividend[PROD_W-1]
              ? WORK_W'($unsigned(-dividend) + PROD_W'(MS_PER_S - 1))
              : WORK_W'($unsigned(dividend));
    part      = {rem_r, work_r[WORK_W-1 -: DIG_W]};
    digit_q   = rprod_r[RCP_SH +: DIG_W];
    back      = PART_W'(digit_q) * PART_W'(MS_PER_S);
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;
    work_nxt  = work_r;
    part_nxt  = part_r;
    rprod_nxt = rprod_r;
    acc_nxt   = acc_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    unique case (st_r)
      D_IDLE: begin
        if (start) begin
          neg_nxt  = dividend[PROD_W-1];
          work_nxt = mag;
          rem_nxt  = '0;
          acc_nxt  = '0;
          cnt_nxt  = CNT_W'(N_DIG);
          st_nxt   = D_MUL;
        end
      end
      D_MUL: begin
        part_nxt  = part;
        rprod_nxt = RPROD_W'(part) * RPROD_W'(RECIP);
        work_nxt  = work_r << DIG_W;
        st_nxt    = D_REM;
      end
      D_REM: begin
        rem_nxt = REM_W'(part_r - back);
        acc_nxt = {acc_r[WORK_W-DIG_W-1:0], digit_q};
        cnt_nxt = cnt_r - 1'b1;
        st_nxt  = (cnt_r == CNT_W'(1)) ? D_FIX : D_MUL;
      end
      D_FIX: begin
        quo_nxt  = neg_r ? -$signed(acc_r[QUO_W-1:0]) : $signed(acc_r[QUO_W-1:0]);
        done_nxt = 1'b1;
        st_nxt   = D_IDLE;
      end
      default: begin
        st_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    rem_r   <= rem_nxt;
    work_r  <= work_nxt;
    part_r  <= part_nxt;
    rprod_r <= rprod_nxt;
    acc_r   <= acc_nxt;
    quo_r   <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = st_r != D_IDLE;
  assign stat.done = done_r;

endmodule

>>> design/damped_spring_integrator_unit.sv
`timescale 1ns / 1ps
// Top level of the damped spring integrator: sequencer, shared multiplier and state.
// Each input transaction runs through a small sequencer around one shared 32x17
// multiplier, and the block takes no new item until the sequencer is back in idle.
// A skipped item (a timestamped item outside the time window, or an explicit-step
// item near the target) goes from the check straight to the output step. An
// explicit-step item that updates takes two multiplies for the force, then a multiply
// and an add for each of the two increments. A timestamped item that updates also
// waits on the divide by 1000 for each of the velocity and position increments; the
// divider works through three 16-bit digits by reciprocal multiplication and holds
// the sequencer while it runs. A finished result sits in an output register, so the
// next transaction is taken while it waits.
module damped_spring_integrator_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_kind,
  input  logic signed [dsi_pkg::DATA_W-1:0]     in_target,
  input  logic [dsi_pkg::DATA_W-1:0]            in_time_ms,
  input  logic [dsi_pkg::STEP_W-1:0]            in_step_seconds,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dsi_pkg::DATA_W-1:0]     out_position,
  output logic                                  out_updated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dsi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dsi_pkg::COEF_W-1:0]            cfg_data
);
  import dsi_pkg::*;

  localparam int      RESET_STATE = ((1 << FRAC_BITS) + MS_PER_S / 2) / MS_PER_S;
  localparam q_word_t STATE_RESET = DATA_W'(RESET_STATE);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MK    = 4'd2;
  localparam logic [3:0] S_MD    = 4'd3;
  localparam logic [3:0] S_FORCE = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_INC   = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_APPLY = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]               state_r, state_nxt;
  logic [COEF_W-1:0]        stiff_r, stiff_nxt;
  logic [COEF_W-1:0]        damp_r, damp_nxt;
  logic [COEF_W-1:0]        tol_r, tol_nxt;
  logic [COEF_W-1:0]        min_r, min_nxt;
  logic [COEF_W-1:0]        max_r, max_nxt;
  q_word_t                  vel_r, vel_nxt;
  q_word_t                  pos_r, pos_nxt;
  logic [DATA_W-1:0]        last_r, last_nxt;
  logic                     kind_r, kind_nxt;
  q_word_t                  tgt_r, tgt_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [DATA_W-1:0]        elapsed_r, elapsed_nxt;
  logic signed [DATA_W:0]   diff_r, diff_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  q_word_t                  force_r, force_nxt;
  logic                     phase_r, phase_nxt;
  logic                     did_r, did_nxt;
  logic                     out_valid_r, out_valid_nxt;
  q_word_t                  out_pos_r, out_pos_nxt;
  logic                     out_upd_r, out_upd_nxt;

  q_word_t                  mul_a;
  logic [STEP_W-1:0]        mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] sh_coef;
  logic signed [PROD_W-1:0] sh_frac;
  logic signed [PROD_W-1:0] inc;
  logic signed [DATA_W:0]   diff_mag;
  logic                     near;
  logic                     in_window;
  logic                     go;
  logic signed [63:0]       sum;
  logic                     div_start;
  logic signed [QUO_W-1:0]  div_q;
  div_stat_t                div_stat;

  dsi_div1000 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_r)
      S_MK: begin
        mul_a = pos_r;
        mul_b = STEP_W'(stiff_r);
      end
      S_MD: begin
        mul_a = vel_r;
        mul_b = STEP_W'(damp_r);
      end
      default: begin
        mul_a = phase_r ? vel_r : force_r;
        mul_b = kind_r ? step_r : STEP_W'(elapsed_r[COEF_W-1:0]);
      end
    endcase
    mul_p = $signed({{(PROD_W-DATA_W){mul_a[DATA_W-1]}}, mul_a})
          * $signed({{(PROD_W-STEP_W){1'b0}}, mul_b});
  end

  always_comb begin
    sh_coef   = prod_r >>> COEF_FRAC;
    sh_frac   = prod_r >>> FRAC_BITS;
    inc       = kind_r ? sh_frac : PROD_W'(div_q);
    diff_mag  = diff_r[DATA_W] ? -diff_r : diff_r;
    near      = $unsigned(diff_mag) < {{(DATA_W+1-COEF_W){1'b0}}, tol_r};
    in_window = (elapsed_r > {{(DATA_W-COEF_W){1'b0}}, min_r})
             && (elapsed_r < {{(DATA_W-COEF_W){1'b0}}, max_r});
    go        = kind_r ? !near : in_window;
    sum       = 64'(phase_r ? pos_r : vel_r) + 64'(inc);
  end

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    stiff_nxt     = stiff_r;
    damp_nxt      = damp_r;
    tol_nxt       = tol_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    vel_nxt       = vel_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    kind_nxt      = kind_r;
    tgt_nxt       = tgt_r;
    step_nxt      = step_r;
    elapsed_nxt   = elapsed_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    force_nxt     = force_r;
    phase_nxt     = phase_r;
    did_nxt       = did_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_upd_nxt   = out_upd_r;
    div_start     = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_STIFFNESS:    stiff_nxt = cfg_data;
        REG_DAMPING:      damp_nxt  = cfg_data;
        REG_TOLERANCE:    tol_nxt   = cfg_data;
        REG_MIN_INTERVAL: min_nxt   = cfg_data;
        REG_MAX_INTERVAL: max_nxt   = cfg_data;
        default: begin
        end
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          tgt_nxt     = in_target;
          step_nxt    = in_step_seconds;
          elapsed_nxt = in_time_ms - last_r;
          diff_nxt    = (DATA_W+1)'(in_target) - (DATA_W+1)'(pos_r);
          phase_nxt   = 1'b0;
          // The stored time follows every timestamped transaction.
          if (!in_kind) begin
            last_nxt = in_time_ms;
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        did_nxt   = go;
        state_nxt = go ? S_MK : S_OUT;
      end
      S_MK: begin
        prod_nxt  = mul_p;
        state_nxt = S_MD;
      end
      S_MD: begin
        acc_nxt   = ACC_W'(tgt_r) - ACC_W'(sh_coef);
        prod_nxt  = mul_p;
        state_nxt = S_FORCE;
      end
      S_FORCE: begin
        force_nxt = sat_word(64'(acc_r - ACC_W'(sh_coef)));
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_INC;
      end
      S_INC: begin
        if (kind_r) begin
          state_nxt = S_APPLY;
        end else begin
          div_start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_stat.done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        // Velocity goes first; the position step then uses the new velocity.
        if (phase_r) begin
          pos_nxt   = sat_word(sum);
          state_nxt = S_OUT;
        end else begin
          vel_nxt   = sat_word(sum);
          phase_nxt = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_upd_nxt   = did_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stiff_r     <= '0;
      damp_r      <= '0;
      tol_r       <= TOL_RESET;
      min_r       <= MIN_RESET;
      max_r       <= MAX_RESET;
      vel_r       <= STATE_RESET;
      pos_r       <= STATE_RESET;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stiff_r     <= stiff_nxt;
      damp_r      <= damp_nxt;
      tol_r       <= tol_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      vel_r       <= vel_nxt;
      pos_r       <= pos_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    tgt_r     <= tgt_nxt;
    step_r    <= step_nxt;
    elapsed_r <= elapsed_nxt;
    diff_r    <= diff_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    force_r   <= force_nxt;
    phase_r   <= phase_nxt;
    did_r     <= did_nxt;
    out_pos_r <= out_pos_nxt;
    out_upd_r <= out_upd_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_updated  = out_upd_r;

  a_div_done_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_WAIT)
    else $error("divider finished outside the wait state");

  a_idle_div_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_stat.busy)
    else $error("divider busy while the sequencer is idle");

  a_pos_write_phase : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && pos_r != $past(pos_r)) |->
      ($past(state_r) == S_APPLY && $past(phase_r)))
    else $error("position changed outside its update step");

endmodule
